// ===== rtl/core/ccw_pkg.sv =====
// shared types and constants for the coin change way counter
package ccw_pkg;

    localparam int unsigned MAX_SUM = 4096;
    localparam int unsigned ADDR_W  = $clog2(MAX_SUM + 1);
    localparam int unsigned COUNT_W = 20;
    localparam int unsigned COIN_W  = 13;

    typedef logic [ADDR_W-1:0]  addr_t;
    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [COIN_W-1:0]  coin_t;

    localparam logic [COUNT_W:0] WAY_MOD   = (COUNT_W + 1)'(1000007);
    localparam addr_t            MAX_ADDR  = ADDR_W'(MAX_SUM);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_READ,
        ST_LOAD
    } ccw_state_t;

    typedef struct packed {
        logic load;
        logic walk;
        logic read_tgt;
        logic clear;
        logic clear_start;
        logic out_load;
    } ccw_cmd_t;

    typedef struct packed {
        logic skip;
        logic walk_last;
        logic clear_last;
        logic out_full;
    } ccw_stat_t;

endpackage

// ===== rtl/core/coin_change_way_count.sv =====
// top level of the coin change way counter
// a coin c <= target t is accepted, walks table entries c through t, then drains;
// a zero coin or one above the target is accepted with no walk
// after the last coin the target entry is read and the result loaded once the output is free
// throughput is set by the single-write-port table walk: one table entry per cycle
// after reset and after each result a clear sweep over all MAX_SUM+1 (4097) entries
// restores the table; no word is accepted during the sweep
module coin_change_way_count
    import ccw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // target sum register write
    input  logic        target_sum_we,
    input  logic [12:0] target_sum_data,
    // coin words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [12:0] coin_value, [15:13] zero
    input  logic        s_tlast,   // last_coin
    // result words
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // [19:0] way_count, [23:20] zero
);

    coin_t     target_sum_reg;
    ccw_cmd_t  cmd;
    ccw_stat_t stat;
    count_t    out_count;

    // target register, resets to one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            target_sum_reg <= coin_t'(1);
        else if (target_sum_we)
            target_sum_reg <= target_sum_data;
    end

    // controller: accepts a coin, walks the table, reads the result, sweeps clear
    ccw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_last  (s_tlast),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // datapath: way table, modular add with write forwarding, output register
    ccw_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .in_coin    (s_tdata[COIN_W-1:0]),
        .target_sum (target_sum_reg),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_count  (out_count)
    );

    assign m_tdata = {4'b0, out_count};

endmodule

// ===== rtl/core/ccw_datapath.sv =====
// way table memory, walk pipeline, clear sweep and result register
module ccw_datapath
    import ccw_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  ccw_cmd_t cmd,
    output ccw_stat_t stat,
    input  coin_t    in_coin,
    input  coin_t    target_sum,
    output logic     out_valid,
    input  logic     out_ready,
    output count_t   out_count
);

    logic [COUNT_W-1:0] mem [0:MAX_SUM];

    coin_t  eff_tgt;
    addr_t  coin_reg, coin_next;
    addr_t  tgt_reg, tgt_next;
    addr_t  idx_reg, idx_next;
    addr_t  s1_idx_reg;
    logic   s1_valid_reg;
    logic   fwd_reg;
    count_t wr_data_reg;
    count_t rd_hi_reg, rd_lo_reg;
    count_t out_data_reg;
    logic   out_valid_reg, out_valid_next;

    addr_t  rd_hi_addr, rd_lo_addr;
    logic   rd_en;
    logic   we;
    addr_t  wa;
    count_t wd;
    count_t lo_sel;
    logic [COUNT_W:0] sum_raw;
    count_t sum_mod;

    // effective target saturates at MAX_SUM, the top table index
    assign eff_tgt = (target_sum > coin_t'(MAX_SUM)) ? coin_t'(MAX_SUM) : target_sum;

    assign stat.skip       = (in_coin == '0) || (in_coin > eff_tgt);
    assign stat.walk_last  = (idx_reg == tgt_reg);
    assign stat.clear_last = (idx_reg == MAX_ADDR);
    assign stat.out_full   = out_valid_reg;

    assign rd_en      = cmd.walk || cmd.read_tgt;
    assign rd_hi_addr = cmd.read_tgt ? tgt_reg : idx_reg;
    assign rd_lo_addr = idx_reg - coin_reg;

    // lower operand comes from the write of the previous cycle when coin is one
    assign lo_sel  = fwd_reg ? wr_data_reg : rd_lo_reg;
    assign sum_raw = {1'b0, rd_hi_reg} + {1'b0, lo_sel};
    assign sum_mod = (sum_raw >= WAY_MOD) ? COUNT_W'(sum_raw - WAY_MOD) : sum_raw[COUNT_W-1:0];

    always_comb
    begin
        we = 1'b0;
        wa = s1_idx_reg;
        wd = sum_mod;
        if (cmd.clear)
        begin
            we = 1'b1;
            wa = idx_reg;
            wd = (idx_reg == '0) ? count_t'(1) : '0;
        end
        else if (s1_valid_reg)
        begin
            we = 1'b1;
        end
    end

    always_comb
    begin
        coin_next = coin_reg;
        tgt_next  = tgt_reg;
        idx_next  = idx_reg;
        if (cmd.load)
        begin
            coin_next = in_coin;
            tgt_next  = eff_tgt;
            idx_next  = in_coin;
        end
        else if (cmd.walk || cmd.clear)
        begin
            idx_next = idx_reg + addr_t'(1);
        end
        else if (cmd.clear_start)
        begin
            idx_next = '0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            fwd_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            s1_valid_reg  <= cmd.walk;
            fwd_reg       <= cmd.walk && s1_valid_reg && (rd_lo_addr == s1_idx_reg);
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        coin_reg <= coin_next;
        tgt_reg  <= tgt_next;
        if (cmd.walk)
            s1_idx_reg <= idx_reg;
        if (s1_valid_reg)
            wr_data_reg <= sum_mod;
        if (cmd.out_load)
            out_data_reg <= rd_hi_reg;
    end

    // table storage
    always_ff @(posedge clk)
    begin
        if (we)
            mem[wa] <= wd;
        if (rd_en)
        begin
            rd_hi_reg <= mem[rd_hi_addr];
            rd_lo_reg <= mem[rd_lo_addr];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_count = out_data_reg;

    a_no_clear_during_walk: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.clear && s1_valid_reg))
        else $error("clear sweep overlaps a walk write");

    a_walk_data_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> ({1'b0, sum_mod} < WAY_MOD))
        else $error("way count not reduced");

    a_load_into_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !out_valid_reg)
        else $error("result loaded over a pending word");

    a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.walk |=> (s1_idx_reg <= tgt_reg) && (s1_idx_reg >= coin_reg))
        else $error("walk index out of range");

endmodule

// ===== rtl/core/ccw_ctrl.sv =====
// sequencer for accept, table walk, result read and clear sweep
module ccw_ctrl
    import ccw_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_last,
    output logic      in_ready,
    input  ccw_stat_t stat,
    output ccw_cmd_t  cmd
);

    ccw_state_t state_reg, state_next;
    logic       last_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (stat.clear_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (!stat.skip)
                        state_next = ST_WALK;
                    else if (in_last)
                        state_next = ST_READ;
                end
            end
            ST_WALK:
            begin
                if (stat.walk_last)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                state_next = last_reg ? ST_READ : ST_IDLE;
            end
            ST_READ:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (!stat.out_full)
                    state_next = ST_CLEAR;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_CLEAR: cmd.clear = 1'b1;
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_WALK:  cmd.walk = 1'b1;
            ST_DRAIN: ;
            ST_READ:  cmd.read_tgt = 1'b1;
            ST_LOAD:
            begin
                cmd.out_load    = !stat.out_full;
                cmd.clear_start = !stat.out_full;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_valid && in_ready)
                last_reg <= in_last;
        end
    end

    a_accept_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg != ST_CLEAR) && (state_reg != ST_LOAD))
        else $error("accept led into clear or load");

endmodule

// ===== tb/coin_change_way_check.sv =====
// checker for the coin change way counter: tracks the way table and compares result words
module coin_change_way_check
    import ccw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        target_sum_we,
    input  logic [12:0] target_sum_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,   // [12:0] coin_value, [15:13] zero
    input  logic        s_tlast,   // last_coin
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,   // [19:0] way_count, [23:20] zero
    output int          pending_words,
    output int          fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    count_t      ways_tab [0:MAX_SUM];
    logic [12:0] target_reg;
    count_t      way_count_q [$];

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t ns: %s", $time, msg);
        fail_count++;
    endtask

    task automatic clear_ways();
        for (int i = 0; i <= MAX_SUM; i++)
        begin
            ways_tab[i] = '0;
        end
        ways_tab[0] = count_t'(1);
    endtask

    // one coin walks the table up to the target in force; a last coin yields the count
    task automatic count_ways(input coin_t coin, input logic last);
        int unsigned      tgt;
        logic [COUNT_W:0] sum;
        tgt = (int'(target_reg) > MAX_SUM) ? MAX_SUM : int'(target_reg);
        if (coin != '0 && coin <= tgt)
        begin
            for (int unsigned i = coin; i <= tgt; i++)
            begin
                sum = ways_tab[i] + ways_tab[i - coin];
                if (sum >= WAY_MOD)
                    sum = sum - WAY_MOD;
                ways_tab[i] = sum[COUNT_W-1:0];
            end
        end
        if (last)
        begin
            way_count_q = {way_count_q, ways_tab[tgt]};
            clear_ways();
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        count_t want;
        if (!rst_n)
        begin
            target_reg = 13'd1;
            clear_ways();
            way_count_q.delete();
            pending_words = 0;
            fail_count = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (way_count_q.size() == 0)
                    report_mismatch($sformatf("unexpected word, way_count %0d",
                                              m_tdata[COUNT_W-1:0]));
                else
                begin
                    want = way_count_q.pop_front();
                    if (m_tdata[COUNT_W-1:0] !== want)
                        report_mismatch($sformatf("way_count %0d, wanted %0d",
                                                  m_tdata[COUNT_W-1:0], want));
                end
            end
            if (s_tvalid && s_tready)
                count_ways(s_tdata[COIN_W-1:0], s_tlast);
            if (target_sum_we)
                target_reg = target_sum_data;
            pending_words = way_count_q.size();
        end
    end

endmodule

// ===== tb/tb_coin_change_way_count.sv =====
// testbench top for the coin change way counter: stimulus, idling and verdict
module tb_coin_change_way_count;
    import ccw_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // worst walk plus the clear sweep, with margin
    localparam int SETTLE_CYCLES = 2 * (MAX_SUM + 1) + 16;
    // cycles with no word moving on either side before giving up
    localparam int STALL_LIMIT   = 40000;
    localparam int RAND_PHASES   = 12;
    localparam int PHASE_WORDS   = 9;

    logic        clk;
    logic        rst_n;
    logic        target_sum_we;
    logic [12:0] target_sum_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // [12:0] coin_value, [15:13] zero
    logic        s_tlast;   // last_coin
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // [19:0] way_count, [23:20] zero

    int pending_words;
    int fail_count;

    // chance in percent that a side idles in a given cycle
    int src_idle_pct  = 26;
    int sink_idle_pct = 47;

    coin_change_way_count u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .target_sum_we   (target_sum_we),
        .target_sum_data (target_sum_data),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tlast         (s_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata)
    );

    coin_change_way_check u_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .target_sum_we   (target_sum_we),
        .target_sum_data (target_sum_data),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tlast         (s_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .pending_words   (pending_words),
        .fail_count      (fail_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // present one coin word, maybe after an idle gap, and hold it until taken
    // valid stays high afterwards so back to back words need no extra edge
    task automatic send_coin(input coin_t coin, input logic last);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, coin};
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // drop valid, wait for all result words, then let a walk and a clear sweep finish
    // pending count is looked at on the falling edge, clear of the checker update
    task automatic quiesce();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (pending_words != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // single register write, only called with the block at rest
    task automatic write_target(input logic [12:0] value);
        target_sum_we   <= 1'b1;
        target_sum_data <= value;
        @(posedge clk);
        target_sum_we   <= 1'b0;
    endtask

    // mostly small targets, one medium, one at the max, one above it (saturates)
    function automatic logic [12:0] pick_target(input int ph);
        case (ph)
            3:       return 13'($urandom_range(900, 200));
            6:       return 13'(MAX_SUM);
            9:       return 13'($urandom_range(8191, MAX_SUM + 1));
            11:      return 13'($urandom_range(4, 1));
            default: return 13'($urandom_range(48, 1));
        endcase
    endfunction

    // mostly coins that walk the table, some zero coins, some above the target
    function automatic coin_t pick_coin(input int unsigned tgt);
        int unsigned r;
        r = $urandom_range(99);
        if (r < 10)
            return '0;
        if (r < 20 || tgt == 0)
            return coin_t'($urandom_range(8191, tgt + 1));
        if (r < 60)
            return coin_t'($urandom_range((tgt < 8) ? tgt : 8, 1));
        return coin_t'($urandom_range(tgt, 1));
    endfunction

    // receiver side: random backpressure per cycle
    initial
    begin : result_sink
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            m_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // watchdog: ends the run when no word moves for too long
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin : stimulus
        logic [12:0] tgt_raw;
        int unsigned tgt_eff;
        int          sent;
        int          set_len;

        rst_n           <= 1'b0;
        target_sum_we   <= 1'b0;
        target_sum_data <= '0;
        s_tvalid        <= 1'b0;
        s_tdata         <= '0;
        s_tlast         <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // reset target of one: single coin, then a lone zero coin marked last
        send_coin(13'd1, 1'b1);
        send_coin(13'd0, 1'b1);
        quiesce();

        // target at the max: smallest and largest coin, then a coin far above
        write_target(13'(MAX_SUM));
        send_coin(13'd1, 1'b0);
        send_coin(13'(MAX_SUM), 1'b1);
        send_coin(13'h1fff, 1'b1);
        quiesce();

        // zero target always counts one way
        write_target(13'd0);
        send_coin(13'd5, 1'b1);
        send_coin(13'd0, 1'b1);
        quiesce();

        // all ones target saturates to the max
        write_target(13'h1fff);
        send_coin(13'(MAX_SUM), 1'b0);
        send_coin(13'd2, 1'b0);
        send_coin(13'(MAX_SUM + 1), 1'b1);
        quiesce();

        // small set, then a target change in the middle of a set
        write_target(13'd10);
        send_coin(13'd2, 1'b0);
        send_coin(13'd5, 1'b0);
        send_coin(13'd3, 1'b1);
        send_coin(13'd3, 1'b0);
        quiesce();
        write_target(13'd20);
        send_coin(13'd7, 1'b0);
        send_coin(13'd20, 1'b1);
        quiesce();

        // large counts that wrap the modulus
        write_target(13'(MAX_SUM));
        send_coin(13'd1, 1'b0);
        send_coin(13'd2, 1'b0);
        send_coin(13'd3, 1'b0);
        send_coin(13'd4, 1'b1);
        quiesce();

        // random sets, one target per phase, idling swapped then switched off
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            if (ph == RAND_PHASES / 3)
            begin
                src_idle_pct  = 47;
                sink_idle_pct = 26;
            end
            else if (ph == 2 * RAND_PHASES / 3)
            begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end
            tgt_raw = pick_target(ph);
            tgt_eff = (int'(tgt_raw) > MAX_SUM) ? MAX_SUM : int'(tgt_raw);
            write_target(tgt_raw);
            sent = 0;
            while (sent < PHASE_WORDS)
            begin
                set_len = $urandom_range(5, 1);
                for (int k = 0; k < set_len; k++)
                begin
                    send_coin(pick_coin(tgt_eff), k == set_len - 1);
                    sent++;
                end
            end
            quiesce();
        end

        if (fail_count == 0 && pending_words == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
